>>> design/srtv_pkg.sv
package srtv_pkg;

    typedef enum logic [2:0] {
        PH_TYPE_LEN,
        PH_TYPE_TXT,
        PH_EXP_LEN,
        PH_EXP_BODY,
        PH_MOD_LEN,
        PH_MOD_BODY,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       last;
        logic       ok;
    } t_byte_item;

    localparam logic [7:0] PAD_CHAR = 8'h3d;
    localparam logic [31:0] TYPE_LEN = 32'd7;
    localparam logic [31:0] MAX_AFTER_LEAD = 32'h1fff_ffff;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= 8'h41 && c <= 8'h5a) v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7a) v = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2b) v = 7'd62;
        else if (c == 8'h2f) v = 7'd63;
        return v;
    endfunction

    function automatic logic [7:0] type_char(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = 8'h73;
            3'd1: r = 8'h73;
            3'd2: r = 8'h68;
            3'd3: r = 8'h2d;
            3'd4: r = 8'h72;
            3'd5: r = 8'h73;
            3'd6: r = 8'h61;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] bit_length8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) n = 4'(k + 1);
        end
        return n;
    endfunction

endpackage

>>> design/srtv_sym_if.sv
interface srtv_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_symbol;
    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

>>> design/srtv_res_if.sv
interface srtv_res_if;
    logic        valid;
    logic        ready;
    logic        token_valid;
    logic [32:0] modulus_len;
    modport source (output valid, output token_valid, output modulus_len, input ready);
    modport sink (input valid, input token_valid, input modulus_len, output ready);
endinterface

>>> design/ssh_rsa_token_validator.sv
// channel   dir  handshake     payload
// i_sym     in   valid/ready   symbol[7:0], last_symbol
// o_res     out  valid/ready   token_valid, modulus_len[32:0]
//
// One character per cycle while ready is high; a result is registered after its
// final character leaves the queue. Rate is set by the decoder stage and the
// byte parser, each handling one transaction per cycle through a four-entry queue.
// Synchronous active-low reset clears all control state; the next token starts clean.
// A stalled result holds the parser on the final entry; the queue then fills
// and drops ready on the input.
module ssh_rsa_token_validator
    import srtv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    srtv_sym_if.sink   i_sym,
    srtv_res_if.source o_res
);
    logic       push, full, pop, empty;
    t_byte_item din, dout;

    srtv_decoder u_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sym(i_sym),
        .o_push(push), .o_item(din), .i_full(full)
    );

    srtv_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(din),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_item(dout)
    );

    srtv_parser u_par (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_item(dout),
        .o_pop(pop), .o_res(o_res)
    );
endmodule

>>> design/srtv_decoder.sv
module srtv_decoder
    import srtv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    srtv_sym_if.sink   i_sym,
    output logic       o_push,
    output t_byte_item o_item,
    input  logic       i_full
);
    logic [1:0] r_pos, n_pos;
    logic [5:0] r_carry, n_carry;
    logic [1:0] r_pad, n_pad;
    logic       r_fail, n_fail;
    logic [6:0] v;
    logic       pad, emit;
    logic [7:0] b;

    assign i_sym.ready = !i_full;
    assign o_push = i_sym.valid && !i_full;

    always_comb begin
        v = sextet_of(i_sym.symbol);
        pad = (i_sym.symbol == PAD_CHAR);
        n_pos = r_pos + 2'd1;
        n_carry = r_carry;
        n_pad = r_pad;
        n_fail = r_fail;
        emit = 1'b0;
        b = 8'h00;
        if (r_pad == 2'd2) begin
            n_fail = 1'b1;
        end else begin
            case (r_pos)
                2'd0: begin
                    if (v[6]) n_fail = 1'b1; else n_carry = v[5:0];
                end
                2'd1: begin
                    if (v[6]) n_fail = 1'b1;
                    else begin
                        emit = 1'b1;
                        b = {r_carry, v[5:4]};
                        n_carry = v[5:0];
                    end
                end
                2'd2: begin
                    if (pad) begin
                        if (r_carry[3:0] != 4'd0) n_fail = 1'b1;
                        n_pad = 2'd1;
                    end else if (v[6]) n_fail = 1'b1;
                    else begin
                        emit = 1'b1;
                        b = {r_carry[3:0], v[5:2]};
                        n_carry = v[5:0];
                    end
                end
                default: begin
                    if (r_pad == 2'd1) begin
                        if (!pad) n_fail = 1'b1;
                        n_pad = 2'd2;
                    end else if (pad) begin
                        if (r_carry[1:0] != 2'd0) n_fail = 1'b1;
                        n_pad = 2'd2;
                    end else if (v[6]) n_fail = 1'b1;
                    else begin
                        emit = 1'b1;
                        b = {r_carry[1:0], v[5:0]};
                    end
                end
            endcase
        end
        o_item.has_byte = emit && !r_fail && !(r_pad == 2'd2);
        o_item.data = b;
        o_item.last = i_sym.last_symbol;
        o_item.ok = !n_fail && (r_pos == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_carry <= '0;
            r_pad <= '0;
            r_fail <= 1'b0;
        end else if (o_push) begin
            if (i_sym.last_symbol) begin
                r_pos <= '0;
                r_carry <= '0;
                r_pad <= '0;
                r_fail <= 1'b0;
            end else begin
                r_pos <= n_pos;
                r_carry <= n_carry;
                r_pad <= n_pad;
                r_fail <= n_fail;
            end
        end
    end
endmodule

>>> design/srtv_fifo.sv
module srtv_fifo
    import srtv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_byte_item i_item,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_empty,
    output t_byte_item o_item
);
    t_byte_item r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end
endmodule

>>> design/srtv_parser.sv
module srtv_parser
    import srtv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_byte_item i_item,
    output logic       o_pop,
    srtv_res_if.source o_res
);
    t_phase      r_ph, n_ph;
    logic [1:0]  r_lbc, n_lbc;
    logic [31:0] r_rem, n_rem;
    logic [2:0]  r_tix, n_tix;
    logic [1:0]  r_mph, n_mph;
    logic [31:0] r_bal, n_bal;
    logic [3:0]  r_lhb, n_lhb;
    logic [32:0] r_mbits, n_mbits;
    logic        r_pf, n_pf;
    logic        r_ov;
    logic        r_tv;
    logic [32:0] r_mb;
    logic        can_take;
    logic [7:0]  b;
    logic        fin_ok;

    assign can_take = !r_ov || o_res.ready;
    assign o_pop = !i_empty && (can_take || !i_item.last);
    assign b = i_item.data;

    always_comb begin
        n_ph = r_ph;
        n_lbc = r_lbc;
        n_rem = r_rem;
        n_tix = r_tix;
        n_mph = r_mph;
        n_bal = r_bal;
        n_lhb = r_lhb;
        n_mbits = r_mbits;
        n_pf = r_pf;
        if (i_item.has_byte && !r_pf) begin
            unique case (r_ph)
                PH_TYPE_LEN, PH_EXP_LEN, PH_MOD_LEN: begin
                    n_rem = {r_rem[23:0], b};
                    n_lbc = r_lbc + 2'd1;
                    if (r_lbc == 2'd3) begin
                        if (r_ph == PH_TYPE_LEN) begin
                            if (n_rem != TYPE_LEN) n_pf = 1'b1;
                            else begin
                                n_tix = '0;
                                n_ph = PH_TYPE_TXT;
                            end
                        end else if (n_rem == 32'd0) n_pf = 1'b1;
                        else begin
                            n_mph = '0;
                            n_bal = '0;
                            n_lhb = '0;
                            n_ph = (r_ph == PH_EXP_LEN) ? PH_EXP_BODY : PH_MOD_BODY;
                        end
                    end
                end
                PH_TYPE_TXT: begin
                    if (r_tix == 3'd7 || b != type_char(r_tix)) n_pf = 1'b1;
                    else begin
                        n_tix = r_tix + 3'd1;
                        if (r_tix == 3'd6) begin
                            n_tix = '0;
                            n_rem = '0;
                            n_ph = PH_EXP_LEN;
                        end
                    end
                end
                PH_EXP_BODY, PH_MOD_BODY: begin
                    if (r_mph == 2'd0) begin
                        if (b[7]) n_pf = 1'b1;
                        else if (b == 8'd0) n_mph = 2'd1;
                        else begin
                            n_lhb = bit_length8(b);
                            n_mph = 2'd2;
                        end
                    end else if (r_mph == 2'd1) begin
                        if (!b[7]) n_pf = 1'b1;
                        else begin
                            n_lhb = bit_length8(b);
                            n_mph = 2'd2;
                        end
                    end else n_bal = r_bal + 32'd1;
                    if (!n_pf) begin
                        n_rem = r_rem - 32'd1;
                        if (r_rem == 32'd1) begin
                            if (n_mph != 2'd2 || n_bal > MAX_AFTER_LEAD) n_pf = 1'b1;
                            else begin
                                if (r_ph == PH_MOD_BODY)
                                    n_mbits = {n_bal[29:0], 3'b000} + 33'(n_lhb);
                                n_ph = (r_ph == PH_EXP_BODY) ? PH_MOD_LEN : PH_DONE;
                            end
                        end
                    end
                end
                default: n_pf = 1'b1;
            endcase
        end
        fin_ok = i_item.ok && !n_pf && (n_ph == PH_DONE);
    end

    assign o_res.valid = r_ov;
    assign o_res.token_valid = r_tv;
    assign o_res.modulus_len = r_mb;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_tv <= fin_ok;
            r_mb <= fin_ok ? n_mbits : 33'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_TYPE_LEN;
            r_lbc <= '0;
            r_rem <= '0;
            r_tix <= '0;
            r_mph <= '0;
            r_bal <= '0;
            r_lhb <= '0;
            r_mbits <= '0;
            r_pf <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_pop && i_item.last) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
            if (o_pop) begin
                if (i_item.last) begin
                    r_ph <= PH_TYPE_LEN;
                    r_lbc <= '0;
                    r_rem <= '0;
                    r_tix <= '0;
                    r_mph <= '0;
                    r_bal <= '0;
                    r_lhb <= '0;
                    r_mbits <= '0;
                    r_pf <= 1'b0;
                end else begin
                    r_ph <= n_ph;
                    r_lbc <= n_lbc;
                    r_rem <= n_rem;
                    r_tix <= n_tix;
                    r_mph <= n_mph;
                    r_bal <= n_bal;
                    r_lhb <= n_lhb;
                    r_mbits <= n_mbits;
                    r_pf <= n_pf;
                end
            end
        end
    end
endmodule
